// ===== rtl/core/dtkv_pkg.sv =====
`default_nettype none
package dtkv_pkg;

  localparam logic [7:0] ChrNewline   = 8'h0A;
  localparam logic [7:0] ChrSpace     = 8'h20;
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrFooter    = 8'h44;  // 'D'
  localparam logic [7:0] ChrPrintLo   = 8'h20;
  localparam logic [7:0] ChrPrintHi   = 8'h7E;

  localparam logic [2:0] FooterLen = 3'd7;

  localparam logic [2:0] StRunning   = 3'd0;
  localparam logic [2:0] StDone      = 3'd1;
  localparam logic [2:0] StNonHex    = 3'd2;
  localparam logic [2:0] StNonPrint  = 3'd3;
  localparam logic [2:0] StEndInByte = 3'd4;
  localparam logic [2:0] StNoValue   = 3'd5;
  localparam logic [2:0] StBadStart  = 3'd6;

  localparam logic RegPrintMode    = 1'b0;
  localparam logic RegLeadingSpace = 1'b1;

  typedef enum logic [6:0] {
    PH_LINE   = 7'b0000001,
    PH_FIELD  = 7'b0000010,
    PH_HEXLO  = 7'b0000100,
    PH_ESC    = 7'b0001000,
    PH_ESCLO  = 7'b0010000,
    PH_FOOTER = 7'b0100000,
    PH_HOLD   = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nibble;
    logic       high_invalid;
    logic       value_side;
    logic       key_has_bytes;
    logic [2:0] footer_pos;
    logic [2:0] status;
  } state_t;

  typedef struct packed {
    logic       print_mode;
    logic       leading_space;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       in_value;
    logic       field_end;
    logic [2:0] status;
  } result_t;

  // footer text after the leading 'D'
  function automatic logic [7:0] footer_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h41;  // A
      3'd1:    ch = 8'h54;  // T
      3'd2:    ch = 8'h41;  // A
      3'd3:    ch = 8'h3D;  // =
      3'd4:    ch = 8'h45;  // E
      3'd5:    ch = 8'h4E;  // N
      3'd6:    ch = 8'h44;  // D
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {bad, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = {1'b1, 4'h0};
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dtkv_step.sv =====
`default_nettype none
module dtkv_step (
  input  wire dtkv_pkg::state_t  cur,
  input  wire dtkv_pkg::cfg_t    cfg,
  input  wire logic [7:0]        char_in,
  input  wire logic              end_flag,
  output dtkv_pkg::state_t       nxt,
  output dtkv_pkg::result_t      res
);

  logic [4:0] hv;
  logic       body;
  logic       stop;
  logic [2:0] stop_code;

  always_comb begin
    hv        = dtkv_pkg::hex_val(char_in);
    nxt       = cur;
    body      = 1'b0;
    stop      = 1'b0;
    stop_code = dtkv_pkg::StRunning;
    res       = '0;
    res.in_value = cur.value_side;

    case (cur.phase)
      dtkv_pkg::PH_HOLD: begin
      end
      dtkv_pkg::PH_FOOTER: begin
        if (cur.footer_pos != dtkv_pkg::FooterLen) begin
          if (!end_flag && char_in == dtkv_pkg::footer_char(cur.footer_pos)) begin
            nxt.footer_pos = cur.footer_pos + 3'd1;
          end else begin
            stop = 1'b1; stop_code = dtkv_pkg::StBadStart;
          end
        end else if (end_flag || char_in == dtkv_pkg::ChrNewline) begin
          stop = 1'b1; stop_code = dtkv_pkg::StDone;
        end else begin
          stop = 1'b1; stop_code = dtkv_pkg::StBadStart;
        end
      end
      dtkv_pkg::PH_HEXLO: begin
        if (end_flag) begin
          stop = 1'b1; stop_code = dtkv_pkg::StEndInByte;
        end else if (cur.high_invalid || hv[4]) begin
          stop = 1'b1; stop_code = dtkv_pkg::StNonHex;
        end else begin
          res.byte_out   = {cur.high_nibble, hv[3:0]};
          res.byte_valid = 1'b1;
          nxt.phase      = dtkv_pkg::PH_FIELD;
        end
      end
      dtkv_pkg::PH_ESC: begin
        if (end_flag) begin
          stop = 1'b1; stop_code = dtkv_pkg::StEndInByte;
        end else if (char_in == dtkv_pkg::ChrBackslash) begin
          res.byte_out   = dtkv_pkg::ChrBackslash;
          res.byte_valid = 1'b1;
          nxt.phase      = dtkv_pkg::PH_FIELD;
        end else if (hv[4]) begin
          stop = 1'b1; stop_code = dtkv_pkg::StNonHex;
        end else begin
          nxt.high_nibble = hv[3:0];
          nxt.phase       = dtkv_pkg::PH_ESCLO;
        end
      end
      dtkv_pkg::PH_ESCLO: begin
        if (end_flag) begin
          stop = 1'b1; stop_code = dtkv_pkg::StEndInByte;
        end else if (hv[4]) begin
          stop = 1'b1; stop_code = dtkv_pkg::StNonHex;
        end else begin
          res.byte_out   = {cur.high_nibble, hv[3:0]};
          res.byte_valid = 1'b1;
          nxt.phase      = dtkv_pkg::PH_FIELD;
        end
      end
      dtkv_pkg::PH_LINE: begin
        if (cfg.leading_space) begin
          if (end_flag) begin
            stop = 1'b1;
            stop_code = cur.value_side ? dtkv_pkg::StNoValue : dtkv_pkg::StDone;
          end else if (char_in == dtkv_pkg::ChrSpace) begin
            nxt.phase = dtkv_pkg::PH_FIELD;
          end else if (char_in == dtkv_pkg::ChrFooter && !cur.value_side) begin
            nxt.footer_pos = 3'd0;
            nxt.phase      = dtkv_pkg::PH_FOOTER;
          end else begin
            stop = 1'b1; stop_code = dtkv_pkg::StBadStart;
          end
        end else begin
          body = 1'b1;
        end
      end
      dtkv_pkg::PH_FIELD: body = 1'b1;
      default: begin
        stop = 1'b1; stop_code = dtkv_pkg::StBadStart;
      end
    endcase

    if (body) begin
      nxt.phase = dtkv_pkg::PH_FIELD;
      if (end_flag) begin
        stop = 1'b1;
        if (cur.value_side) begin
          res.field_end = 1'b1;
          stop_code     = dtkv_pkg::StDone;
        end else if (cfg.leading_space || cur.key_has_bytes) begin
          stop_code = dtkv_pkg::StNoValue;
        end else begin
          stop_code = dtkv_pkg::StDone;
        end
      end else if (char_in == dtkv_pkg::ChrNewline) begin
        res.field_end  = 1'b1;
        nxt.value_side = ~cur.value_side;
        if (cur.value_side) begin
          nxt.key_has_bytes = 1'b0;
        end
        nxt.phase = dtkv_pkg::PH_LINE;
      end else if (cfg.print_mode) begin
        if (char_in == dtkv_pkg::ChrBackslash) begin
          nxt.phase = dtkv_pkg::PH_ESC;
        end else if (char_in >= dtkv_pkg::ChrPrintLo && char_in <= dtkv_pkg::ChrPrintHi) begin
          res.byte_out   = char_in;
          res.byte_valid = 1'b1;
        end else begin
          stop = 1'b1; stop_code = dtkv_pkg::StNonPrint;
        end
      end else begin
        nxt.high_invalid = hv[4];
        nxt.high_nibble  = hv[3:0];
        nxt.phase        = dtkv_pkg::PH_HEXLO;
      end
    end

    // a completed byte on a key line marks the key as non-empty
    if (res.byte_valid && !cur.value_side) begin
      nxt.key_has_bytes = 1'b1;
    end

    if (stop) begin
      nxt.phase  = dtkv_pkg::PH_HOLD;
      nxt.status = stop_code;
    end
    res.status = nxt.status;
  end

endmodule
`default_nettype wire

// ===== rtl/core/dump_text_key_value_deframer_unit.sv =====
// an accepted character's result word is registered and is valid in the cycle after acceptance
// throughput: one character per cycle unless result_stall holds a full result register;
// the parse step is a single pass of logic between the parser state register and the result register
// reset: parser returns to key line start, print_mode 0, leading_space 1,
// result register empty
`default_nettype none
module dump_text_key_value_deframer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic       wr_index,
  input  wire logic       wr_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       end_flag,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      byte_out,
  output logic            byte_valid,
  output logic            in_value,
  output logic            field_end,
  output logic [2:0]      status
);

  dtkv_pkg::state_t  state;
  dtkv_pkg::state_t  state_next;
  dtkv_pkg::cfg_t    cfg;
  dtkv_pkg::result_t res_next;
  logic              accept;

  dtkv_step u_step (
    .cur      (state),
    .cfg      (cfg),
    .char_in  (char_in),
    .end_flag (end_flag),
    .nxt      (state_next),
    .res      (res_next)
  );

  // a new word enters whenever the result register is free or being drained
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.print_mode    <= 1'b0;
      cfg.leading_space <= 1'b1;
    end else if (wr_en) begin
      if (wr_index == dtkv_pkg::RegPrintMode) begin
        cfg.print_mode <= wr_data;
      end else begin
        cfg.leading_space <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= dtkv_pkg::PH_LINE;
      state.high_nibble   <= 4'h0;
      state.high_invalid  <= 1'b0;
      state.value_side    <= 1'b0;
      state.key_has_bytes <= 1'b0;
      state.footer_pos    <= 3'd0;
      state.status        <= dtkv_pkg::StRunning;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out   <= res_next.byte_out;
      byte_valid <= res_next.byte_valid;
      in_value   <= res_next.in_value;
      field_end  <= res_next.field_end;
      status     <= res_next.status;
    end
  end

endmodule
`default_nettype wire

// ===== dv/dump_text_key_value_deframer_unit_test.sv =====
`timescale 1ns / 100ps
module dump_text_key_value_deframer_unit_test;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int ReportLimit = 40;
  localparam logic [55:0] FooterTail = "ATA=END";

  typedef enum logic [6:0] {
    AT_LINE   = 7'b0000001,
    IN_FIELD  = 7'b0000010,
    HEX_LOW   = 7'b0000100,
    ESC_FIRST = 7'b0001000,
    ESC_LOW   = 7'b0010000,
    IN_FOOTER = 7'b0100000,
    STOPPED   = 7'b1000000
  } parse_step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en = 1'b0;
  logic       wr_index = 1'b0;
  logic       wr_data = 1'b0;
  logic       item_valid = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic       end_flag = 1'b0;
  logic       result_stall = 1'b0;
  logic       item_stall;
  logic       result_valid;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       in_value;
  logic       field_end;
  logic [2:0] status;

  dump_text_key_value_deframer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .char_in      (char_in),
    .end_flag     (end_flag),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .byte_out     (byte_out),
    .byte_valid   (byte_valid),
    .in_value     (in_value),
    .field_end    (field_end),
    .status       (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser copy, reset values
  parse_step_t mdl_step = AT_LINE;
  logic [3:0]  mdl_high = 4'h0;
  logic        mdl_high_bad = 1'b0;
  logic        mdl_value = 1'b0;
  logic        mdl_key_seen = 1'b0;
  logic [2:0]  mdl_foot = 3'd0;
  logic [2:0]  mdl_status = dtkv_pkg::StRunning;
  logic        mdl_print = 1'b0;
  logic        mdl_lead = 1'b1;

  dtkv_pkg::result_t decoded_words[$];
  int      items_sent = 0;
  int      fails = 0;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;
  int      hold_requests = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      cycle_count = 0;

  // {bad, value}
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic void halt(input logic [2:0] code);
    mdl_step = STOPPED;
    mdl_status = code;
  endfunction

  function automatic dtkv_pkg::result_t decode_char(input logic [7:0] c, input logic e);
    dtkv_pkg::result_t w;
    logic [4:0] d;
    logic [7:0] b;
    logic       got;
    w = '0;
    b = 8'h00;
    got = 1'b0;
    w.in_value = mdl_value;
    d = digit_value(c);
    case (mdl_step)
      STOPPED: ;
      IN_FOOTER: begin
        if (mdl_foot < dtkv_pkg::FooterLen) begin
          if (!e && c == FooterTail[8 * (6 - int'(mdl_foot)) +: 8]) mdl_foot++;
          else halt(dtkv_pkg::StBadStart);
        end else if (e || c == dtkv_pkg::ChrNewline) begin
          halt(dtkv_pkg::StDone);
        end else begin
          halt(dtkv_pkg::StBadStart);
        end
      end
      HEX_LOW: begin
        if (e) halt(dtkv_pkg::StEndInByte);
        else if (mdl_high_bad || d[4]) halt(dtkv_pkg::StNonHex);
        else begin
          b = {mdl_high, d[3:0]};
          got = 1'b1;
        end
      end
      ESC_FIRST: begin
        if (e) halt(dtkv_pkg::StEndInByte);
        else if (c == dtkv_pkg::ChrBackslash) begin
          b = dtkv_pkg::ChrBackslash;
          got = 1'b1;
        end else if (d[4]) halt(dtkv_pkg::StNonHex);
        else begin
          mdl_high = d[3:0];
          mdl_step = ESC_LOW;
        end
      end
      ESC_LOW: begin
        if (e) halt(dtkv_pkg::StEndInByte);
        else if (d[4]) halt(dtkv_pkg::StNonHex);
        else begin
          b = {mdl_high, d[3:0]};
          got = 1'b1;
        end
      end
      default: begin
        if (mdl_step == AT_LINE && mdl_lead) begin
          if (e) halt(mdl_value ? dtkv_pkg::StNoValue : dtkv_pkg::StDone);
          else if (c == dtkv_pkg::ChrSpace) mdl_step = IN_FIELD;
          else if (c == dtkv_pkg::ChrFooter && !mdl_value) begin
            mdl_foot = 3'd0;
            mdl_step = IN_FOOTER;
          end else halt(dtkv_pkg::StBadStart);
        end else begin
          mdl_step = IN_FIELD;
          if (e) begin
            // end in a value closes it; in a nonempty or spaced key: no value
            if (mdl_value) begin
              w.field_end = 1'b1;
              halt(dtkv_pkg::StDone);
            end else if (mdl_lead || mdl_key_seen) halt(dtkv_pkg::StNoValue);
            else halt(dtkv_pkg::StDone);
          end else if (c == dtkv_pkg::ChrNewline) begin
            w.field_end = 1'b1;
            mdl_value = !mdl_value;
            if (!mdl_value) mdl_key_seen = 1'b0;
            mdl_step = AT_LINE;
          end else if (mdl_print) begin
            if (c == dtkv_pkg::ChrBackslash) mdl_step = ESC_FIRST;
            else if (c >= dtkv_pkg::ChrPrintLo && c <= dtkv_pkg::ChrPrintHi) begin
              b = c;
              got = 1'b1;
            end else halt(dtkv_pkg::StNonPrint);
          end else begin
            // a bad high digit only shows up with the low digit
            mdl_high_bad = d[4];
            mdl_high = d[3:0];
            mdl_step = HEX_LOW;
          end
        end
      end
    endcase
    if (got) begin
      w.byte_out = b;
      w.byte_valid = 1'b1;
      if (!mdl_value) mdl_key_seen = 1'b1;
      mdl_step = IN_FIELD;
    end
    w.status = (mdl_step == STOPPED) ? mdl_status : dtkv_pkg::StRunning;
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      fails++;
      // keep the log short when everything is off
      if (fails <= ReportLimit) $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    dtkv_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (decoded_words.size() == 0) begin
        fails++;
        $error("result word with no word expected");
      end else begin
        want = decoded_words.pop_front();
        check_field("byte_out", want.byte_out, byte_out);
        check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
        check_field("in_value", 8'(want.in_value), 8'(in_value));
        check_field("field_end", 8'(want.field_end), 8'(field_end));
        check_field("status", 8'(want.status), 8'(status));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("dump_text_key_value_deframer_unit: mismatch");
    $finish;
  end

  task automatic send_word(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    char_in <= c;
    end_flag <= e;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    decoded_words.push_back(decode_char(c, e));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    item_valid <= 1'b0;
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == dtkv_pkg::RegPrintMode) mdl_print = val;
    else mdl_lead = val;
  endtask

  task automatic set_mode(input logic print, input logic lead);
    write_reg(dtkv_pkg::RegPrintMode, print);
    write_reg(dtkv_pkg::RegLeadingSpace, lead);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic send_data_byte(input logic [7:0] b);
    if (!mdl_print) begin
      send_word(hex_digit(b[7:4]), 1'b0);
      send_word(hex_digit(b[3:0]), 1'b0);
    end else if (b >= dtkv_pkg::ChrPrintLo && b <= dtkv_pkg::ChrPrintHi &&
                 b != dtkv_pkg::ChrBackslash && $urandom_range(3) != 0) begin
      send_word(b, 1'b0);
    end else if (b == dtkv_pkg::ChrBackslash && $urandom_range(1)) begin
      send_word(dtkv_pkg::ChrBackslash, 1'b0);
      send_word(dtkv_pkg::ChrBackslash, 1'b0);
    end else begin
      send_word(dtkv_pkg::ChrBackslash, 1'b0);
      send_word(hex_digit(b[7:4]), 1'b0);
      send_word(hex_digit(b[3:0]), 1'b0);
    end
  endtask

  task automatic line_start();
    if (mdl_lead) send_word(dtkv_pkg::ChrSpace, 1'b0);
  endtask

  function automatic logic [7:0] random_data();
    return $urandom_range(1) ? 8'($urandom_range(8'h7E, 8'h20)) : 8'($urandom_range(255));
  endfunction

  task automatic send_field(input int len);
    line_start();
    repeat (len) send_data_byte(random_data());
    send_word(dtkv_pkg::ChrNewline, 1'b0);
  endtask

  function automatic int random_len();
    return ($urandom_range(9) == 0) ? 24 : int'($urandom_range(6));
  endfunction

  task automatic send_pairs_until(input int stop_at);
    while (items_sent < stop_at) begin
      send_field(random_len());
      send_field(random_len());
    end
  endtask

  task automatic test_hex_lines();
    send_text(" 00\n");
    send_text(" Ff\n");
  endtask

  task automatic test_print_lines();
    write_reg(dtkv_pkg::RegPrintMode, 1'b1);
    send_text(" \\\\\n");
    send_text(" \\7f\n");
  endtask

  task automatic test_print_bare_lines();
    write_reg(dtkv_pkg::RegLeadingSpace, 1'b0);
    send_text("\n");
    send_text("~\n");
  endtask

  task automatic test_hex_bare_lines();
    write_reg(dtkv_pkg::RegPrintMode, 1'b0);
    send_text("5A\n");
    send_text("\n");
  endtask

  task automatic test_random_stream(input int src, input int sink, input int n);
    int stop_at;
    stop_at = items_sent + n;
    src_idle_pct = src;
    sink_stall_pct = sink;
    while (items_sent < stop_at) begin
      set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
      send_pairs_until(items_sent + int'($urandom_range(60, 20)));
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
    hold_requests++;
    send_pairs_until(items_sent + 80);
  endtask

  task automatic test_end_of_input();
    int pick;
    pick = int'($urandom_range(17));
    src_idle_pct = 31;
    sink_stall_pct = 31;
    case (pick)
      0, 1: begin
        set_mode(1'($urandom_range(1)), 1'b1);
        send_text("DATA=END");
        if (pick == 0) send_word(dtkv_pkg::ChrNewline, 1'b0);
        else send_word(8'($urandom_range(255)), 1'b1);
      end
      2: begin
        set_mode(1'($urandom_range(1)), 1'b1);
        send_word(8'($urandom_range(255)), 1'b1);
      end
      3: begin
        set_mode(1'($urandom_range(1)), 1'b1);
        send_field(2);
        send_word(8'($urandom_range(255)), 1'b1);
      end
      4: begin
        set_mode(1'b0, 1'b1);
        send_text(" 4g");
      end
      5: begin
        set_mode(1'b0, 1'b1);
        send_text(" x1");
      end
      6: begin
        set_mode(1'b0, 1'b1);
        send_text(" 4\n");
      end
      7: begin
        set_mode(1'b1, 1'($urandom_range(1)));
        line_start();
        send_word(8'($urandom_range(1) ? $urandom_range(255, 127) : $urandom_range(9)),
                  1'b0);
      end
      8: begin
        set_mode(1'b0, 1'($urandom_range(1)));
        line_start();
        send_word(hex_digit(4'($urandom_range(15))), 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
      end
      9: begin
        set_mode(1'($urandom_range(1)), 1'b1);
        send_text("x");
      end
      10: begin
        // footer start on a value line
        set_mode(1'($urandom_range(1)), 1'b1);
        send_field(1);
        send_text("D");
      end
      11: begin
        set_mode(1'($urandom_range(1)), 1'b1);
        send_text("DATB");
      end
      12: begin
        set_mode(1'($urandom_range(1)), 1'b1);
        send_text("DATA=ENDx");
      end
      13: begin
        set_mode(1'b1, 1'b0);
        send_text("ab");
        send_word(8'($urandom_range(255)), 1'b1);
      end
      14: begin
        set_mode(1'($urandom_range(1)), 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
      end
      15: begin
        set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
        send_field(1);
        line_start();
        send_data_byte(random_data());
        send_word(8'($urandom_range(255)), 1'b1);
      end
      default: begin
        set_mode(1'b1, 1'($urandom_range(1)));
        line_start();
        send_word(dtkv_pkg::ChrBackslash, 1'b0);
        if ($urandom_range(1)) send_word(8'h67, 1'b0);
        else send_word(8'($urandom_range(255)), 1'b1);
      end
    endcase
  endtask

  task automatic test_held_status();
    src_idle_pct = 31;
    sink_stall_pct = 31;
    repeat (2) begin
      set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
      repeat (30) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_hex_lines();
    test_print_lines();
    test_print_bare_lines();
    test_hex_bare_lines();
    test_random_stream(0, 0, 180);
    test_random_stream(68, 0, 180);
    test_backpressure();
    test_random_stream(0, 68, 180);
    test_random_stream(31, 31, 180);
    test_end_of_input();
    test_held_status();
    item_valid <= 1'b0;
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) $display("dump_text_key_value_deframer_unit: match");
    else $display("dump_text_key_value_deframer_unit: mismatch");
    $finish;
  end

endmodule
